[rtl/dtb_pkg.sv]
// Shared types, constants and helpers for the distance tree builder.
// No dependencies; imported by distance_tree_builder_top and by the testbench.
package dtb_pkg;

   localparam int IDX_W        = 4;
   localparam int DIST_W       = 24;
   localparam int NODE_W       = 5;
   localparam int TAXA_W       = 5;
   localparam int MAX_TAXA_DEF = 16;
   localparam int MIN_TAXA     = 2;
   localparam int FINAL_NODES  = 3;
   localparam logic [TAXA_W-1:0] TAXA_RESET = 5'd16;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_COPY,
      ST_COPY_DRAIN,
      ST_SRCH_INIT,
      ST_SRCH,
      ST_SRCH_DRAIN,
      ST_MEAN_INIT,
      ST_MEAN,
      ST_MEAN_DRAIN,
      ST_DIVA_GO,
      ST_DIVA_WAIT,
      ST_DIVB_GO,
      ST_DIVB_WAIT,
      ST_EMIT_A,
      ST_EMIT_B,
      ST_MRG_RA,
      ST_MRG_RB,
      ST_MRG_WR,
      ST_MRG_END,
      ST_FIN_INIT,
      ST_FIN_SCAN,
      ST_FIN_RD0,
      ST_FIN_RD1,
      ST_FIN_RD2,
      ST_FIN_RD3,
      ST_FIN_E0,
      ST_FIN_E1,
      ST_FIN_E2,
      ST_HALF_E0,
      ST_HALF_E1
   } state_type;

   // max((x + y - z) / 2, 0), truncating
   function automatic logic [DIST_W-1:0] half_clamp(input logic [DIST_W-1:0] x,
                                                    input logic [DIST_W-1:0] y,
                                                    input logic [DIST_W-1:0] z);
      logic [DIST_W:0] p;
      logic [DIST_W:0] d;
      p = {1'b0, x} + {1'b0, y};
      d = p - {1'b0, z};
      if (p <= {1'b0, z}) begin
         return '0;
      end
      return d[DIST_W:1];
   endfunction

endpackage

[rtl/distance_tree_builder_top.sv]
// Distance tree builder: loads a distance matrix one item per cycle, then
// builds the tree under one sequencer. Depends on dtb_pkg, dtb_ram, dtb_div.
// Load: one item per cycle. Build (after the last item): a copy sweep of the
// working RAM, then per join round scans over the working and original RAM
// ports, two divides and a merge pass over the other live slots, plus emit
// handshakes; a final step emits the edges to the last two or three nodes.
// Not ready for items while building. Synchronous reset clears the sequencer
// and output valid and sets taxa_count to 16; the RAMs are not cleared.
module distance_tree_builder_top #(
   parameter int MAX_TAXA = dtb_pkg::MAX_TAXA_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dtb_pkg::IDX_W-1:0]   req_row_index,
   input  logic [dtb_pkg::IDX_W-1:0]   req_col_index,
   input  logic [dtb_pkg::DIST_W-1:0]  req_distance,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dtb_pkg::NODE_W-1:0]  rsp_parent_node,
   output logic [dtb_pkg::NODE_W-1:0]  rsp_child_node,
   output logic [dtb_pkg::DIST_W-1:0]  rsp_branch_length,
   output logic                        rsp_last_res,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [dtb_pkg::TAXA_W-1:0]  csr_taxa_count
);
   import dtb_pkg::*;

   localparam int IW = $clog2(MAX_TAXA);
   localparam int NS = 2 ** IW;
   localparam int AW = 2 * IW;
   localparam int CW = $clog2(MAX_TAXA + 1);
   localparam int DW = 2 * CW;
   localparam int SW = DIST_W + DW;

   function automatic logic [AW-1:0] canon(input logic [IW-1:0] x,
                                           input logic [IW-1:0] y);
      return (x <= y) ? {x, y} : {y, x};
   endfunction

   state_type state_ff, state_in;

   logic [TAXA_W-1:0] taxa_ff;
   logic [CW-1:0]     n_ff, n_in;
   logic [CW-1:0]     live_ff;
   logic [NODE_W-1:0] next_node_ff;
   logic [NS-1:0]     active_ff;
   logic [NS-1:0]     members_ff [NS];
   logic [NODE_W-1:0] node_ff [NS];
   logic [NS-1:0]     all_mask;

   logic [IW-1:0]     i_ff, j_ff;
   logic [AW-1:0]     ij;
   logic              ij_last, i_last;

   logic              cp_v_ff;
   logic [AW-1:0]     cp_addr_ff;
   logic              sr_v_ff;
   logic [IW-1:0]     sr_i_ff, sr_j_ff;
   logic              mn_a_ff, mn_b_ff;

   logic              found_ff;
   logic [DIST_W-1:0] best_ff;
   logic [IW-1:0]     a_ff, b_ff;
   logic [NS-1:0]     mem_a_ff, mem_b_ff, oth_ff;
   logic [SW-1:0]     sum_a_ff, sum_b_ff;
   logic [CW-1:0]     cnt_a_ff, cnt_b_ff, cnt_o_ff;
   logic [DIST_W-1:0] dao_ff, dbo_ff, tmp_ff;
   logic [IW-1:0]     s0_ff, s1_ff, s2_ff;
   logic [1:0]        fc_ff;
   logic [DIST_W-1:0] ab_ff, ac_ff, bc_ff;

   logic              rsp_valid_ff;
   logic [NODE_W-1:0] out_parent_ff, out_child_ff;
   logic [DIST_W-1:0] out_len_ff;
   logic              out_last_ff;

   logic              req_fire, in_range, rsp_fire;
   logic [IW-1:0]     ri, ci;
   logic              srch_elig, mrg_elig, emit_state;
   logic [NODE_W-1:0] e_child;
   logic [DIST_W-1:0] e_len;
   logic              e_last;

   logic              o_we, w_we;
   logic [AW-1:0]     o_waddr, o_raddr, w_waddr, w_raddr;
   logic [DIST_W-1:0] o_rdata, w_rdata, w_wdata;
   logic [DIST_W:0]   mrg_sum;

   logic              div_start, div_done;
   logic [SW-1:0]     div_num, div_quot;
   logic [DW-1:0]     div_den;

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign in_range  = (int'(req_row_index) < MAX_TAXA) && (int'(req_col_index) < MAX_TAXA);
   assign ri        = IW'(req_row_index);
   assign ci        = IW'(req_col_index);
   assign ij        = {i_ff, j_ff};
   assign ij_last   = &ij;
   assign i_last    = &i_ff;

   always_comb begin
      int t;
      t = int'(taxa_ff);
      if (t < MIN_TAXA) begin
         t = MIN_TAXA;
      end else if (t > MAX_TAXA) begin
         t = MAX_TAXA;
      end
      n_in = CW'(t);
   end

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         all_mask[k] = k < int'(n_ff);
      end
   end

   assign srch_elig = (j_ff > i_ff) && active_ff[i_ff] && active_ff[j_ff];
   assign mrg_elig  = active_ff[i_ff] && (i_ff != a_ff) && (i_ff != b_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_fire && req_last) state_in = ST_COPY;
         ST_COPY:       if (ij_last) state_in = ST_COPY_DRAIN;
         ST_COPY_DRAIN: state_in = (live_ff > CW'(FINAL_NODES)) ? ST_SRCH_INIT : ST_FIN_INIT;
         ST_SRCH_INIT:  state_in = ST_SRCH;
         ST_SRCH:       if (ij_last) state_in = ST_SRCH_DRAIN;
         ST_SRCH_DRAIN: state_in = ST_MEAN_INIT;
         ST_MEAN_INIT:  state_in = ST_MEAN;
         ST_MEAN:       if (ij_last) state_in = ST_MEAN_DRAIN;
         ST_MEAN_DRAIN: state_in = ST_DIVA_GO;
         ST_DIVA_GO:    state_in = ST_DIVA_WAIT;
         ST_DIVA_WAIT:  if (div_done) state_in = ST_DIVB_GO;
         ST_DIVB_GO:    state_in = ST_DIVB_WAIT;
         ST_DIVB_WAIT:  if (div_done) state_in = ST_EMIT_A;
         ST_EMIT_A:     if (rsp_fire) state_in = ST_EMIT_B;
         ST_EMIT_B:     if (rsp_fire) state_in = ST_MRG_RA;
         ST_MRG_RA: begin
            if (mrg_elig) begin
               state_in = ST_MRG_RB;
            end else if (i_last) begin
               state_in = ST_MRG_END;
            end
         end
         ST_MRG_RB:     state_in = ST_MRG_WR;
         ST_MRG_WR:     state_in = i_last ? ST_MRG_END : ST_MRG_RA;
         ST_MRG_END: begin
            state_in = ((live_ff - CW'(1)) > CW'(FINAL_NODES)) ? ST_SRCH_INIT : ST_FIN_INIT;
         end
         ST_FIN_INIT:   state_in = ST_FIN_SCAN;
         ST_FIN_SCAN:   if (i_last) state_in = ST_FIN_RD0;
         ST_FIN_RD0:    state_in = ST_FIN_RD1;
         ST_FIN_RD1:    state_in = ST_FIN_RD2;
         ST_FIN_RD2:    state_in = ST_FIN_RD3;
         ST_FIN_RD3:    state_in = (fc_ff == 2'(FINAL_NODES)) ? ST_FIN_E0 : ST_HALF_E0;
         ST_FIN_E0:     if (rsp_fire) state_in = ST_FIN_E1;
         ST_FIN_E1:     if (rsp_fire) state_in = ST_FIN_E2;
         ST_FIN_E2:     if (rsp_fire) state_in = ST_IDLE;
         ST_HALF_E0:    if (rsp_fire) state_in = ST_HALF_E1;
         ST_HALF_E1:    if (rsp_fire) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: RAM ports, divider start, edge selection
   always_comb begin
      o_we      = req_fire && in_range;
      o_waddr   = canon(ri, ci);
      o_raddr   = (state_ff == ST_MEAN) ? canon(i_ff, j_ff) : ij;
      w_we      = 1'b0;
      w_waddr   = cp_addr_ff;
      w_wdata   = o_rdata;
      w_raddr   = ij;
      mrg_sum   = {1'b0, tmp_ff} + {1'b0, w_rdata};
      div_start = 1'b0;
      div_num   = sum_a_ff;
      div_den   = DW'(cnt_a_ff) * DW'(cnt_o_ff);
      emit_state = 1'b0;
      e_child   = '0;
      e_len     = '0;
      e_last    = 1'b0;
      if (cp_v_ff) begin
         w_we = 1'b1;
      end
      case (state_ff)
         ST_MRG_RA:  w_raddr = canon(a_ff, i_ff);
         ST_MRG_RB:  w_raddr = canon(b_ff, i_ff);
         ST_MRG_WR: begin
            w_we    = 1'b1;
            w_waddr = canon(a_ff, i_ff);
            w_wdata = mrg_sum[DIST_W:1];
         end
         ST_FIN_RD0: w_raddr = {s0_ff, s1_ff};
         ST_FIN_RD1: w_raddr = {s0_ff, s2_ff};
         ST_FIN_RD2: w_raddr = {s1_ff, s2_ff};
         ST_DIVA_GO: div_start = 1'b1;
         ST_DIVB_GO: begin
            div_start = 1'b1;
            div_num   = sum_b_ff;
            div_den   = DW'(cnt_b_ff) * DW'(cnt_o_ff);
         end
         ST_EMIT_A: begin
            emit_state = 1'b1;
            e_child    = node_ff[a_ff];
            e_len      = half_clamp(dao_ff, best_ff, dbo_ff);
         end
         ST_EMIT_B: begin
            emit_state = 1'b1;
            e_child    = node_ff[b_ff];
            e_len      = half_clamp(dbo_ff, best_ff, dao_ff);
         end
         ST_FIN_E0: begin
            emit_state = 1'b1;
            e_child    = node_ff[s0_ff];
            e_len      = half_clamp(ab_ff, ac_ff, bc_ff);
         end
         ST_FIN_E1: begin
            emit_state = 1'b1;
            e_child    = node_ff[s1_ff];
            e_len      = half_clamp(ab_ff, bc_ff, ac_ff);
         end
         ST_FIN_E2: begin
            emit_state = 1'b1;
            e_child    = node_ff[s2_ff];
            e_len      = half_clamp(ac_ff, bc_ff, ab_ff);
            e_last     = 1'b1;
         end
         ST_HALF_E0: begin
            emit_state = 1'b1;
            e_child    = node_ff[s0_ff];
            e_len      = ab_ff >> 1;
         end
         ST_HALF_E1: begin
            emit_state = 1'b1;
            e_child    = node_ff[s1_ff];
            e_len      = ab_ff >> 1;
            e_last     = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         taxa_ff      <= TAXA_RESET;
         cp_v_ff      <= 1'b0;
         sr_v_ff      <= 1'b0;
         mn_a_ff      <= 1'b0;
         mn_b_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            taxa_ff <= csr_taxa_count;
         end
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end else if (emit_state && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end
         cp_v_ff <= state_ff == ST_COPY;
         sr_v_ff <= (state_ff == ST_SRCH) && srch_elig;
         mn_a_ff <= (state_ff == ST_MEAN) && mem_a_ff[i_ff] && oth_ff[j_ff];
         mn_b_ff <= (state_ff == ST_MEAN) && mem_b_ff[i_ff] && oth_ff[j_ff];
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= ij;
      sr_i_ff    <= i_ff;
      sr_j_ff    <= j_ff;
      if (emit_state && !rsp_valid_ff) begin
         out_parent_ff <= next_node_ff;
         out_child_ff  <= e_child;
         out_len_ff    <= e_len;
         out_last_ff   <= e_last;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_last) begin
               n_ff         <= n_in;
               live_ff      <= n_in;
               next_node_ff <= NODE_W'(n_in);
               for (int k = 0; k < NS; k++) begin
                  active_ff[k]  <= k < int'(n_in);
                  members_ff[k] <= NS'(1) << k;
                  node_ff[k]    <= NODE_W'(k);
               end
               i_ff <= '0;
               j_ff <= '0;
            end
         end
         ST_COPY, ST_SRCH: {i_ff, j_ff} <= ij + AW'(1);
         ST_SRCH_INIT: begin
            i_ff     <= '0;
            j_ff     <= '0;
            found_ff <= 1'b0;
         end
         ST_MEAN_INIT: begin
            mem_a_ff <= members_ff[a_ff];
            mem_b_ff <= members_ff[b_ff];
            oth_ff   <= all_mask & ~(members_ff[a_ff] | members_ff[b_ff]);
            sum_a_ff <= '0;
            sum_b_ff <= '0;
            cnt_a_ff <= '0;
            cnt_b_ff <= '0;
            cnt_o_ff <= '0;
            i_ff     <= '0;
            j_ff     <= '0;
         end
         ST_MEAN: begin
            // count each cluster once per row and the outside leaves once per column
            if (j_ff == '0 && mem_a_ff[i_ff]) cnt_a_ff <= cnt_a_ff + CW'(1);
            if (j_ff == '0 && mem_b_ff[i_ff]) cnt_b_ff <= cnt_b_ff + CW'(1);
            if (i_ff == '0 && oth_ff[j_ff])   cnt_o_ff <= cnt_o_ff + CW'(1);
            {i_ff, j_ff} <= ij + AW'(1);
         end
         ST_DIVA_WAIT: if (div_done) dao_ff <= div_quot[DIST_W-1:0];
         ST_DIVB_WAIT: if (div_done) dbo_ff <= div_quot[DIST_W-1:0];
         ST_EMIT_B:    if (rsp_fire) i_ff <= '0;
         ST_MRG_RA:    if (!mrg_elig) i_ff <= i_ff + IW'(1);
         ST_MRG_RB:    tmp_ff <= w_rdata;
         ST_MRG_WR:    i_ff <= i_ff + IW'(1);
         ST_MRG_END: begin
            // merged node takes the lower slot; the higher one drops out
            node_ff[a_ff]    <= next_node_ff;
            members_ff[a_ff] <= mem_a_ff | mem_b_ff;
            active_ff[b_ff]  <= 1'b0;
            live_ff          <= live_ff - CW'(1);
            next_node_ff     <= next_node_ff + NODE_W'(1);
         end
         ST_FIN_INIT: begin
            i_ff  <= '0;
            fc_ff <= '0;
            s0_ff <= '0;
            s1_ff <= '0;
            s2_ff <= '0;
         end
         ST_FIN_SCAN: begin
            if (active_ff[i_ff] && fc_ff != 2'(FINAL_NODES)) begin
               case (fc_ff)
                  2'd0:    s0_ff <= i_ff;
                  2'd1:    s1_ff <= i_ff;
                  default: s2_ff <= i_ff;
               endcase
               fc_ff <= fc_ff + 2'd1;
            end
            i_ff <= i_ff + IW'(1);
         end
         ST_FIN_RD1: ab_ff <= w_rdata;
         ST_FIN_RD2: ac_ff <= w_rdata;
         ST_FIN_RD3: bc_ff <= w_rdata;
         default: ;
      endcase
      // closest pair: strict compare keeps the earliest row, then column
      if (sr_v_ff && (!found_ff || w_rdata < best_ff)) begin
         found_ff <= 1'b1;
         best_ff  <= w_rdata;
         a_ff     <= sr_i_ff;
         b_ff     <= sr_j_ff;
      end
      if (mn_a_ff) sum_a_ff <= sum_a_ff + SW'(o_rdata);
      if (mn_b_ff) sum_b_ff <= sum_b_ff + SW'(o_rdata);
   end

   dtb_ram #(.WIDTH(DIST_W), .DEPTH(2 ** AW)) u_orig_ram (
      .clock (clock),
      .we    (o_we),
      .waddr (o_waddr),
      .wdata (req_distance),
      .raddr (o_raddr),
      .rdata (o_rdata)
   );

   dtb_ram #(.WIDTH(DIST_W), .DEPTH(2 ** AW)) u_work_ram (
      .clock (clock),
      .we    (w_we),
      .waddr (w_waddr),
      .wdata (w_wdata),
      .raddr (w_raddr),
      .rdata (w_rdata)
   );

   dtb_div #(.NW(SW), .DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_parent_node   = out_parent_ff;
   assign rsp_child_node    = out_child_ff;
   assign rsp_branch_length = out_len_ff;
   assign rsp_last_res      = out_last_ff;

endmodule

[rtl/dtb_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dtb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/dtb_div.sv]
// Restoring divider, one quotient bit per cycle; divide by zero gives zero.
// No dependencies.
module dtb_div #(
   parameter int NW = 36,
   parameter int DW = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quotient
);

   localparam int CTW = (NW > 1) ? $clog2(NW) : 1;

   logic           busy_ff;
   logic           done_ff;
   logic [CTW-1:0] cnt_ff;
   logic [DW-1:0]  rem_ff;
   logic [NW-1:0]  quo_ff;
   logic [DW-1:0]  dsr_ff;
   logic           zero_ff;
   logic [DW:0]    rem_sh;
   logic           fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NW-1]};
      fits   = rem_sh >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CTW'(NW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
         zero_ff <= divisor == '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DW'(rem_sh - {1'b0, dsr_ff});
         end else begin
            rem_ff <= rem_sh[DW-1:0];
         end
         quo_ff <= {quo_ff[NW-2:0], fits};
         cnt_ff <= cnt_ff + CTW'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff;

endmodule

[verif/tb.sv]
// Self-checking testbench for distance_tree_builder_top: loads distance matrices, predicts
// every tree edge in SystemVerilog and checks the result channel. Depends on dtb_pkg and distance_tree_builder_top.
module tb;
   import dtb_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [DIST_W-1:0] dval;
      logic              last;
   } entry_type;

   typedef struct {
      logic [NODE_W-1:0] parent;
      logic [NODE_W-1:0] child;
      logic [DIST_W-1:0] blen;
      logic              fin;
   } tree_edge_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [IDX_W-1:0] req_row_index = '0;
   logic [IDX_W-1:0] req_col_index = '0;
   logic [DIST_W-1:0] req_distance = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [NODE_W-1:0] rsp_parent_node;
   logic [NODE_W-1:0] rsp_child_node;
   logic [DIST_W-1:0] rsp_branch_length;
   logic rsp_last_res;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [TAXA_W-1:0] csr_taxa_count = '0;

   distance_tree_builder_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_row_index(req_row_index), .req_col_index(req_col_index),
      .req_distance(req_distance), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_parent_node(rsp_parent_node), .rsp_child_node(rsp_child_node),
      .rsp_branch_length(rsp_branch_length), .rsp_last_res(rsp_last_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_taxa_count(csr_taxa_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   entry_type     entry_q[$];
   tree_edge_type edge_q[$];
   int            errors = 0;
   int            item_total = 0;
   bit            arm_hold = 0;
   bit            written [0:15][0:15];

   // predictor state
   logic [DIST_W-1:0] orig_dist [0:15][0:15];
   logic [DIST_W-1:0] work_dist [0:15][0:15];
   logic [NODE_W-1:0] slot_node [0:15];
   logic [15:0]       slot_set [0:15];
   bit                slot_on [0:15];
   logic [NODE_W-1:0] node_next = '0;
   logic [TAXA_W-1:0] taxa_reg = TAXA_RESET;

   function automatic int pop_count(logic [15:0] m);
      int c;
      c = 0;
      for (int i = 0; i < 16; i++) c += m[i];
      return c;
   endfunction

   function automatic logic [DIST_W-1:0] mean_between(logic [15:0] xm, logic [15:0] om);
      longint unsigned s;
      longint unsigned cnt;
      s = 0;
      cnt = pop_count(xm) * pop_count(om);
      if (cnt == 0) return '0;
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 16; j++)
            if (xm[i] && om[j]) s += orig_dist[i][j];
      return DIST_W'(s / cnt);
   endfunction

   function automatic logic [DIST_W-1:0] half_diff(longint unsigned p, longint unsigned q);
      if (p <= q) return '0;
      return DIST_W'((p - q) >> 1);
   endfunction

   function automatic void push_edge(logic [NODE_W-1:0] p, logic [NODE_W-1:0] c,
                                     logic [DIST_W-1:0] len, logic fin);
      tree_edge_type e;
      e.parent = p;
      e.child = c;
      e.blen = len;
      e.fin = fin;
      edge_q = {edge_q, e};
   endfunction

   // Join closest pairs until three or two nodes remain; queue every edge.
   function automatic void grow_tree();
      int n, live, a, b, c;
      int s[3];
      logic [15:0] all_set, un, others;
      logic [DIST_W-1:0] best, dab, dao, dbo, ab, ac, bc;
      logic [NODE_W-1:0] node;
      n = taxa_reg;
      if (n < MIN_TAXA) n = MIN_TAXA;
      if (n > 16) n = 16;
      all_set = 16'((32'd1 << n) - 1);
      work_dist = orig_dist;
      for (int i = 0; i < 16; i++) begin
         slot_node[i] = NODE_W'(i);
         slot_set[i] = 16'(1 << i);
         slot_on[i] = (i < n);
      end
      node_next = NODE_W'(n);
      live = n;
      while (live > FINAL_NODES) begin
         a = -1;
         b = -1;
         best = '0;
         for (int i = 0; i < 16; i++) begin
            if (!slot_on[i]) continue;
            for (int j = i + 1; j < 16; j++) begin
               if (!slot_on[j]) continue;
               if (a < 0 || work_dist[i][j] < best) begin
                  best = work_dist[i][j];
                  a = i;
                  b = j;
               end
            end
         end
         node = node_next;
         node_next = node_next + NODE_W'(1);
         un = slot_set[a] | slot_set[b];
         others = all_set & ~un;
         dab = work_dist[a][b];
         dao = mean_between(slot_set[a], others);
         dbo = mean_between(slot_set[b], others);
         push_edge(node, slot_node[a], half_diff(longint'(dao) + dab, dbo), 1'b0);
         push_edge(node, slot_node[b], half_diff(longint'(dbo) + dab, dao), 1'b0);
         for (int i = 0; i < 16; i++) begin
            logic [DIST_W:0] sum;
            if (!slot_on[i] || i == a || i == b) continue;
            sum = {1'b0, work_dist[a][i]} + {1'b0, work_dist[b][i]};
            work_dist[a][i] = sum[DIST_W:1];
            work_dist[i][a] = sum[DIST_W:1];
         end
         slot_node[a] = node;
         slot_set[a] = un;
         slot_on[b] = 0;
         live--;
      end
      node = node_next;
      node_next = node_next + NODE_W'(1);
      c = 0;
      for (int i = 0; i < 16 && c < 3; i++)
         if (slot_on[i]) begin
            s[c] = i;
            c++;
         end
      if (c == 3) begin
         ab = work_dist[s[0]][s[1]];
         ac = work_dist[s[0]][s[2]];
         bc = work_dist[s[1]][s[2]];
         push_edge(node, slot_node[s[0]], half_diff(longint'(ab) + ac, bc), 1'b0);
         push_edge(node, slot_node[s[1]], half_diff(longint'(ab) + bc, ac), 1'b0);
         push_edge(node, slot_node[s[2]], half_diff(longint'(ac) + bc, ab), 1'b1);
      end else begin
         ab = work_dist[s[0]][s[1]] >> 1;
         push_edge(node, slot_node[s[0]], ab, 1'b0);
         push_edge(node, slot_node[s[1]], ab, 1'b1);
      end
   endfunction

   // driver: bursts of items with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      entry_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            cur = entry_q.pop_front();
            orig_dist[cur.row][cur.col] = cur.dval;
            orig_dist[cur.col][cur.row] = cur.dval;
            if (cur.last) grow_tree();
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (entry_q.size() > 0) begin
               req_valid <= 1'b1;
               req_row_index <= entry_q[0].row;
               req_col_index <= entry_q[0].col;
               req_distance <= entry_q[0].dval;
               req_last <= entry_q[0].last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(0, 4);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern plus one long hold-off
   int pat_left = 0;
   int pat_mode = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (arm_hold && !hold_done && rsp_valid) begin
         hold_done = 1;
         hold_left = 3000;
         rsp_ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_mode = $urandom_range(0, 2);
            pat_left = $urandom_range(5, 60);
         end
         pat_left--;
         case (pat_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      tree_edge_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (edge_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected edge parent=%0d child=%0d len=%h last=%b",
                        rsp_parent_node, rsp_child_node, rsp_branch_length, rsp_last_res);
         end else begin
            e = edge_q.pop_front();
            if (e.parent !== rsp_parent_node || e.child !== rsp_child_node ||
                e.blen !== rsp_branch_length || e.fin !== rsp_last_res) begin
               errors++;
               if (errors <= 10)
                  $display("edge mismatch: exp %0d %0d %h %b got %0d %0d %h %b",
                           e.parent, e.child, e.blen, e.fin, rsp_parent_node,
                           rsp_child_node, rsp_branch_length, rsp_last_res);
            end
         end
      end
   end

   function automatic void add_item(int r, int c, logic [DIST_W-1:0] d, logic l);
      entry_type t;
      t.row = IDX_W'(r);
      t.col = IDX_W'(c);
      t.dval = d;
      t.last = l;
      entry_q = {entry_q, t};
      written[r][c] = 1;
      written[c][r] = 1;
      item_total++;
   endfunction

   function automatic logic [DIST_W-1:0] rand_dist();
      case ($urandom_range(0, 5))
         0: return DIST_W'($urandom_range(0, 3));
         1: return '1;
         2: return DIST_W'($urandom_range(0, 4095));
         default: return DIST_W'($urandom);
      endcase
   endfunction

   // Write every pair below n (all, or only the missing ones), then noise, then last.
   function automatic void load_matrix(int n, bit full, int noise);
      for (int i = 0; i < n; i++)
         for (int j = i + 1; j < n; j++)
            if (full || !written[i][j]) begin
               if ($urandom_range(0, 1)) add_item(j, i, rand_dist(), 1'b0);
               else add_item(i, j, rand_dist(), 1'b0);
            end
      for (int k = 0; k < noise; k++)
         add_item($urandom_range(0, 15), $urandom_range(0, 15), rand_dist(), 1'b0);
      add_item($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_dist(), 1'b1);
   endfunction

   task automatic wait_quiet();
      while (entry_q.size() > 0 || req_valid || edge_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_taxa(int v);
      wait_quiet();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_taxa_count <= TAXA_W'(v);
      do @(posedge clock); while (!csr_ready);
      taxa_reg = TAXA_W'(v);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int n, cfg, waited;
      for (int i = 0; i < 16; i++)
         for (int j = 0; j < 16; j++) written[i][j] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // two taxa: zero and full-scale distance
      write_taxa(2);
      add_item(0, 1, '0, 1'b1);
      add_item(1, 0, '1, 1'b1);
      // taxa count below range saturates to two
      write_taxa(0);
      add_item(0, 1, 24'd5, 1'b1);
      // three taxa, one lopsided to force a clamp
      write_taxa(3);
      add_item(0, 2, 24'd7, 1'b0);
      add_item(2, 1, '1, 1'b0);
      add_item(0, 1, 24'd3, 1'b1);
      // four taxa, all tied
      write_taxa(4);
      add_item(0, 1, 24'd4, 1'b0);
      add_item(2, 0, 24'd4, 1'b0);
      add_item(0, 3, 24'd4, 1'b0);
      add_item(1, 2, 24'd4, 1'b0);
      add_item(3, 1, 24'd4, 1'b0);
      add_item(2, 3, 24'd4, 1'b1);
      // rebuild from the current matrix
      add_item(3, 3, 24'd9, 1'b1);
      // full sixteen taxa, then rebuilds queued behind it under a long hold-off
      write_taxa(16);
      arm_hold = 1;
      load_matrix(16, 1, 0);
      add_item(5, 9, rand_dist(), 1'b0);
      add_item(0, 0, rand_dist(), 1'b1);
      add_item(2, 7, '0, 1'b1);
      // taxa count above range saturates to sixteen
      write_taxa(31);
      add_item(15, 14, rand_dist(), 1'b1);
      write_taxa(17);
      add_item(0, 15, 24'd1, 1'b1);
      while (item_total < 250) begin
         case ($urandom_range(0, 9))
            0: cfg = $urandom_range(0, 1);
            1: cfg = $urandom_range(9, 31);
            default: cfg = $urandom_range(2, 8);
         endcase
         n = (cfg < 2) ? 2 : (cfg > 16 ? 16 : cfg);
         // keep the item total near its target
         if (item_total + n * (n - 1) + 12 > 270) begin
            cfg = $urandom_range(2, 4);
            n = cfg;
         end
         write_taxa(cfg);
         case ($urandom_range(0, 4))
            0: load_matrix(n, 0, $urandom_range(0, 6));
            1: begin
               load_matrix(n, 1, 0);
               load_matrix(n, $urandom_range(0, 1), $urandom_range(0, 3));
            end
            default: load_matrix(n, 1, $urandom_range(0, 2));
         endcase
      end
      waited = 0;
      while ((entry_q.size() > 0 || req_valid || edge_q.size() > 0) && waited < 2000000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (edge_q.size() > 0) errors++;
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #(400_000_000);
      $display("tb failed");
      $finish;
   end

endmodule

[distance_tree_builder_top.f]
rtl/dtb_pkg.sv
rtl/dtb_ram.sv
rtl/dtb_div.sv
rtl/distance_tree_builder_top.sv
verif/tb.sv
